### rtl/lprfv_pkg.sv
// lprfv_pkg: shared constants, widths and the arctangent table for the foot velocity block
// used by every file in rtl; depends on nothing
package lprfv_pkg;

    localparam int SINCOS_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_STEPS      = (SINCOS_ITERATIONS < ATAN_ENTRIES) ?
                                       SINCOS_ITERATIONS : ATAN_ENTRIES;
    // fold stage, one stage per step, rounding stage
    localparam int CORDIC_LAT        = CORDIC_STEPS + 2;
    // trig products, rate products, sums, rounding
    localparam int VEL_LAT           = 4;
    localparam int TOTAL_LAT         = CORDIC_LAT + VEL_LAT;

    localparam int CW = 34;
    localparam int TW = 17;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [TW-1:0] t_trig;

    localparam t_cw HALF_PI_Q30 = 34'sd1686629713;
    localparam t_cw PI_Q30      = 34'sd3373259426;
    localparam t_cw GAIN_Q30    = 34'sd652032874;

    function automatic t_cw atan_q30(input logic [4:0] idx);
        t_cw v;
        unique case (idx)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/lprfv_cordic.sv
// lprfv_cordic: pipelined rotation cordic, one stage per step, sine and cosine in Q1.15
// depends on lprfv_pkg
module lprfv_cordic (
    input  logic                   i_clk,
    input  logic signed [15:0]     i_angle,
    output lprfv_pkg::t_trig       o_sin,
    output lprfv_pkg::t_trig       o_cos
);
    import lprfv_pkg::*;

    t_cw  r_x [0:CORDIC_STEPS];
    t_cw  r_y [0:CORDIC_STEPS];
    t_cw  r_z [0:CORDIC_STEPS];
    logic r_f [0:CORDIC_STEPS];
    t_trig r_sin, r_cos;

    t_cw n_z0;
    assign n_z0 = t_cw'(i_angle) <<< 17;

    // quadrant fold
    always_ff @(posedge i_clk) begin
        r_x[0] <= GAIN_Q30;
        r_y[0] <= '0;
        if (n_z0 > HALF_PI_Q30) begin
            r_z[0] <= n_z0 - PI_Q30;
            r_f[0] <= 1'b1;
        end else if (n_z0 < -HALF_PI_Q30) begin
            r_z[0] <= n_z0 + PI_Q30;
            r_f[0] <= 1'b1;
        end else begin
            r_z[0] <= n_z0;
            r_f[0] <= 1'b0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            r_f[i+1] <= r_f[i];
            if (!r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - atan_q30(5'(i));
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + atan_q30(5'(i));
            end
        end
    end

    function automatic t_trig to_q15(input t_cw v, input logic flip);
        t_cw  s;
        logic signed [CW-16:0] r;
        s = flip ? -v : v;
        r = (CW-15)'((s + t_cw'(1 <<< 14)) >>> 15);
        if (r > 32768)       return t_trig'(32768);
        else if (r < -32768) return t_trig'(-32768);
        else                 return t_trig'(r);
    endfunction

    always_ff @(posedge i_clk) begin
        r_cos <= to_q15(r_x[CORDIC_STEPS], r_f[CORDIC_STEPS]);
        r_sin <= to_q15(r_y[CORDIC_STEPS], r_f[CORDIC_STEPS]);
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

### rtl/lprfv_vel.sv
// lprfv_vel: product, sum and rounding pipeline from trig values and rates to velocity
// depends on lprfv_pkg
module lprfv_vel (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lprfv_pkg::t_trig   i_sr,
    input  lprfv_pkg::t_trig   i_cr,
    input  lprfv_pkg::t_trig   i_sp,
    input  lprfv_pkg::t_trig   i_cp,
    input  logic [15:0]        i_len,
    input  logic signed [15:0] i_dlen,
    input  logic signed [15:0] i_droll,
    input  logic signed [15:0] i_dpitch,
    output logic               o_valid,
    output logic signed [23:0] o_vel_x,
    output logic signed [23:0] o_vel_y,
    output logic signed [23:0] o_vel_z
);
    import lprfv_pkg::*;

    logic [VEL_LAT-1:0] r_vld;

    logic signed [32:0] r_e, r_w, r_dlsr, r_dlsr_b;
    logic signed [33:0] r_cs, r_ss, r_cc, r_sc;
    logic signed [15:0] r_dlen;
    t_trig              r_cr;

    logic signed [49:0] r_t1, r_t4, r_t6;
    logic signed [66:0] r_t2, r_t3, r_t5, r_t7;

    logic signed [69:0] r_sx, r_sy, r_sz;
    logic signed [23:0] r_vx, r_vy, r_vz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VEL_LAT-2:0], i_valid};
        end
    end

    // length times rates, trig products
    always_ff @(posedge i_clk) begin
        r_e    <= i_droll * $signed({1'b0, i_len});
        r_w    <= i_dpitch * $signed({1'b0, i_len});
        r_dlsr <= i_dlen * i_sr;
        r_cs   <= i_cr * i_sp;
        r_ss   <= i_sr * i_sp;
        r_cc   <= i_cr * i_cp;
        r_sc   <= i_sr * i_cp;
        r_dlen <= i_dlen;
        r_cr   <= i_cr;
    end

    // terms before shifts: trig products in Q30, r_t4 and r_dlsr_b in Q15
    always_ff @(posedge i_clk) begin
        r_t1     <= r_dlen * r_cs;
        r_t2     <= r_e * r_ss;
        r_t3     <= r_w * r_cc;
        r_t4     <= r_e * r_cr;
        r_t5     <= r_e * r_sc;
        r_t6     <= r_dlen * r_cc;
        r_t7     <= r_w * r_cs;
        r_dlsr_b <= r_dlsr;
    end

    always_ff @(posedge i_clk) begin
        r_sx <= (70'(r_t1) <<< 14) - 70'(r_t2) + 70'(r_t3);
        r_sy <= (70'(r_dlsr_b) <<< 29) + (70'(r_t4) <<< 15);
        r_sz <= 70'(r_t5) - (70'(r_t6) <<< 14) + 70'(r_t7);
    end

    function automatic logic signed [23:0] finish(input logic signed [69:0] s);
        logic signed [29:0] r;
        r = 30'((s + 70'sd549755813888) >>> 40);
        if (r > 30'sd8388607)       return 24'sh7FFFFF;
        else if (r < -30'sd8388608) return 24'sh800000;
        else                        return 24'(r);
    endfunction

    always_ff @(posedge i_clk) begin
        r_vx <= finish(r_sx);
        r_vy <= finish(r_sy);
        r_vz <= finish(r_sz);
    end

    assign o_valid = r_vld[VEL_LAT-1];
    assign o_vel_x = r_vx;
    assign o_vel_y = r_vy;
    assign o_vel_z = r_vz;
endmodule

### rtl/leg_polar_rate_to_foot_velocity.sv
// leg_polar_rate_to_foot_velocity: one leg's polar state and rates to foot velocity
// each word passes through the cordic stages and then the velocity pipeline
// throughput one word per cycle; busy stays low, the receiver cannot stall
// synchronous active-low reset clears the valid pipeline, data stages are not reset
// depends on lprfv_pkg, lprfv_cordic, lprfv_vel
module leg_polar_rate_to_foot_velocity (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_leg_length,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_length_rate,
    input  logic signed [15:0] i_roll_rate,
    input  logic signed [15:0] i_pitch_rate,
    output logic               o_valid,
    output logic signed [23:0] o_vel_x,
    output logic signed [23:0] o_vel_y,
    output logic signed [23:0] o_vel_z
);
    import lprfv_pkg::*;

    logic [CORDIC_LAT-1:0] r_vld;
    logic [15:0]        r_len    [0:CORDIC_LAT-1];
    logic signed [15:0] r_dlen   [0:CORDIC_LAT-1];
    logic signed [15:0] r_droll  [0:CORDIC_LAT-1];
    logic signed [15:0] r_dpitch [0:CORDIC_LAT-1];

    t_trig sr, cr, sp, cp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORDIC_LAT-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_len[0]    <= i_leg_length;
        r_dlen[0]   <= i_length_rate;
        r_droll[0]  <= i_roll_rate;
        r_dpitch[0] <= i_pitch_rate;
        for (int k = 1; k < CORDIC_LAT; k++) begin
            r_len[k]    <= r_len[k-1];
            r_dlen[k]   <= r_dlen[k-1];
            r_droll[k]  <= r_droll[k-1];
            r_dpitch[k] <= r_dpitch[k-1];
        end
    end

    lprfv_cordic u_roll (
        .i_clk   (i_clk),
        .i_angle (i_roll_angle),
        .o_sin   (sr),
        .o_cos   (cr)
    );

    lprfv_cordic u_pitch (
        .i_clk   (i_clk),
        .i_angle (i_pitch_angle),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    lprfv_vel u_vel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_vld[CORDIC_LAT-1]),
        .i_sr     (sr),
        .i_cr     (cr),
        .i_sp     (sp),
        .i_cp     (cp),
        .i_len    (r_len[CORDIC_LAT-1]),
        .i_dlen   (r_dlen[CORDIC_LAT-1]),
        .i_droll  (r_droll[CORDIC_LAT-1]),
        .i_dpitch (r_dpitch[CORDIC_LAT-1]),
        .o_valid  (o_valid),
        .o_vel_x  (o_vel_x),
        .o_vel_y  (o_vel_y),
        .o_vel_z  (o_vel_z)
    );
endmodule

### rtl/lprfv_checker.sv
// lprfv_checker: port-level checks of busy, latency and zero-motion results, bound to the top level
// depends on lprfv_pkg and leg_polar_rate_to_foot_velocity
module lprfv_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [15:0]        i_leg_length,
    input logic signed [15:0] i_length_rate,
    input logic               o_valid,
    input logic signed [23:0] o_vel_x,
    input logic signed [23:0] o_vel_y,
    input logic signed [23:0] o_vel_z
);
    import lprfv_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##TOTAL_LAT o_valid)
        else $error("accepted word gave no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##TOTAL_LAT !o_valid)
        else $error("result without a word");

    a_still_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_leg_length == 16'd0 && i_length_rate == 16'sd0) |-> ##TOTAL_LAT
        (o_vel_x == 24'sd0 && o_vel_y == 24'sd0 && o_vel_z == 24'sd0))
        else $error("nonzero velocity for a still leg");
endmodule

bind leg_polar_rate_to_foot_velocity lprfv_checker u_lprfv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_leg_length  (i_leg_length),
    .i_length_rate (i_length_rate),
    .o_valid       (o_valid),
    .o_vel_x       (o_vel_x),
    .o_vel_y       (o_vel_y),
    .o_vel_z       (o_vel_z)
);

### test/leg_polar_rate_to_foot_velocity_chk.sv
`timescale 1ns / 1ps
// foot velocity checker: watches accepted leg words and velocity strobes, predicts
// each velocity with its own cordic and fixed-point sums; depends on lprfv_pkg
module leg_polar_rate_to_foot_velocity_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [15:0]        i_leg_length,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_length_rate,
    input  logic signed [15:0] i_roll_rate,
    input  logic signed [15:0] i_pitch_rate,
    input  logic               i_valid,
    input  logic signed [23:0] i_vel_x,
    input  logic signed [23:0] i_vel_y,
    input  logic signed [23:0] i_vel_z,
    output int                 o_fail_count,
    output int                 o_pending
);
    import lprfv_pkg::*;

    typedef struct {
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic signed [23:0] vz;
    } t_velocity;

    t_velocity velocity_fifo[$];
    int        mismatch_count;

    localparam longint ARC_TAB[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    function automatic longint q15_round(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32768) r = 32768;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void trig_pair(input logic signed [15:0] ang,
                                      output longint s, output longint c);
        longint z, x, y, dx, dy;
        bit     mirror;
        z = longint'(ang) * 131072;
        x = 64'sd652032874;
        y = 0;
        mirror = 0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            mirror = 1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            mirror = 1;
        end
        for (int i = 0; i < SINCOS_ITERATIONS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARC_TAB[i];
            end else begin
                x += dx;
                y -= dy;
                z += ARC_TAB[i];
            end
        end
        if (mirror) begin
            x = -x;
            y = -y;
        end
        c = q15_round(x);
        s = q15_round(y);
    endfunction

    function automatic logic signed [23:0] q16_sat(input longint s);
        longint r;
        r = (s + (64'sd1 <<< 39)) >>> 40;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    function automatic t_velocity foot_velocity(input logic [15:0] len,
            input logic signed [15:0] roll, input logic signed [15:0] pitch,
            input logic signed [15:0] dlen, input logic signed [15:0] droll,
            input logic signed [15:0] dpitch);
        longint    sr, cr, sp, cp, e, w, l, dl;
        t_velocity v;
        trig_pair(roll, sr, cr);
        trig_pair(pitch, sp, cp);
        l  = longint'({1'b0, len});
        dl = longint'(dlen);
        e  = longint'(droll) * l;
        w  = longint'(dpitch) * l;
        v.vx = q16_sat(dl * cr * sp * 16384 - e * sr * sp + w * cr * cp);
        v.vy = q16_sat(dl * sr * 64'sd536870912 + e * cr * 32768);
        v.vz = q16_sat(e * cp * sr - dl * cr * cp * 16384 + w * cr * sp);
        return v;
    endfunction

    assign o_fail_count = mismatch_count;
    assign o_pending    = velocity_fifo.size();

    always @(posedge i_clk) begin
        t_velocity want;
        if (!i_rst_n) begin
            velocity_fifo.delete();
            mismatch_count = 0;
        end else begin
            if (i_start && !i_busy)
                velocity_fifo.push_back(foot_velocity(i_leg_length, i_roll_angle,
                    i_pitch_angle, i_length_rate, i_roll_rate, i_pitch_rate));
            if (i_valid) begin
                if (velocity_fifo.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected velocity word x=%0d y=%0d z=%0d",
                                 i_vel_x, i_vel_y, i_vel_z);
                end else begin
                    want = velocity_fifo.pop_front();
                    if (want.vx !== i_vel_x || want.vy !== i_vel_y
                            || want.vz !== i_vel_z) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("velocity mismatch exp %0d %0d %0d got %0d %0d %0d",
                                     want.vx, want.vy, want.vz, i_vel_x, i_vel_y, i_vel_z);
                    end
                end
            end
        end
    end
endmodule

### test/leg_polar_rate_to_foot_velocity_tb.sv
`timescale 1ns / 1ps
// foot velocity testbench top: drives directed and random leg words with gaps
// depends on lprfv_pkg, the block and leg_polar_rate_to_foot_velocity_chk
module leg_polar_rate_to_foot_velocity_tb;
    import lprfv_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic [15:0]        i_leg_length = '0;
    logic signed [15:0] i_roll_angle = '0;
    logic signed [15:0] i_pitch_angle = '0;
    logic signed [15:0] i_length_rate = '0;
    logic signed [15:0] i_roll_rate = '0;
    logic signed [15:0] i_pitch_rate = '0;
    logic               o_valid;
    logic signed [23:0] o_vel_x, o_vel_y, o_vel_z;
    int                 fail_count, pending;
    int                 idle_cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    leg_polar_rate_to_foot_velocity dut (
        .i_clk, .i_rst_n, .start, .busy, .i_leg_length, .i_roll_angle,
        .i_pitch_angle, .i_length_rate, .i_roll_rate, .i_pitch_rate,
        .o_valid, .o_vel_x, .o_vel_y, .o_vel_z);

    leg_polar_rate_to_foot_velocity_chk chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_leg_length,
        .i_roll_angle, .i_pitch_angle, .i_length_rate, .i_roll_rate,
        .i_pitch_rate, .i_valid(o_valid), .i_vel_x(o_vel_x), .i_vel_y(o_vel_y),
        .i_vel_z(o_vel_z), .o_fail_count(fail_count), .o_pending(pending));

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'(int'($urandom_range(0, 25736)) - 12868);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic [15:0] l, input logic [15:0] r,
            input logic [15:0] p, input logic [15:0] dl, input logic [15:0] dr,
            input logic [15:0] dp);
        start         <= 1;
        i_leg_length  <= l;
        i_roll_angle  <= r;
        i_pitch_angle <= p;
        i_length_rate <= dl;
        i_roll_rate   <= dr;
        i_pitch_rate  <= dp;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic gap();
        int n;
        if ($urandom_range(0, 2) != 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
            start <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [15:0] angles[8];
        angles = '{16'h8000, 16'h7fff, 16'h0000, 16'd12868, 16'd12869,
                   -16'sd12868, -16'sd12869, 16'd25736};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (angles[k])
            send_word(16'hffff, angles[k], angles[(k + 3) % 8], 16'h7fff,
                      16'h8000, 16'h7fff);
        send_word(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'hffff, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
        send_word(16'hffff, 16'd12868, 16'h8000, 16'h8000, 16'h7fff, 16'h8000);
        send_word(16'h4000, 16'h1000, 16'hf000, 16'h1000, 16'hf000, 16'h0800);
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < 1700; n++) begin
            send_word(pick16(), pick16(), pick16(), pick16(), pick16(), pick16());
            if (n > 400) gap();
            if (n == 900) begin
                start <= 0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        start <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
